// ===== sv/rmspm_pkg.sv =====
// Shared types and constants for the RMS and real power window meter.
// Used by rmspm_front, rmspm_fifo, rmspm_back and rms_and_power_window_meter.
package rmspm_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int WLEN_BITS     = 11;
  localparam int MAX_WINDOW    = 1024;
  localparam int WLEN_RESET    = 64;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS;
  localparam int SQ_SUM_BITS   = 41;
  localparam int PROD_SUM_BITS = 42;
  localparam int RMS_BITS      = 16;
  localparam int POWER_BITS    = 32;

  // Window queue between front and back
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = 1;
  localparam int QCNT_BITS     = 2;

  // Iterative units in the back end
  localparam int DIV_BITS      = PROD_SUM_BITS;
  localparam int REM_BITS      = WLEN_BITS;
  localparam int SQRT_IN_BITS  = 2 * RMS_BITS;
  localparam int SQRT_ITERS    = RMS_BITS;
  localparam int SREM_BITS     = RMS_BITS + 4;
  localparam int STEP_BITS     = 6;

  // Finished window sums handed from front to back
  typedef struct packed {
    logic [SQ_SUM_BITS-1:0]   vsq;
    logic [SQ_SUM_BITS-1:0]   isq;
    logic [PROD_SUM_BITS-1:0] psum;
    logic [WLEN_BITS-1:0]     wlen;
  } win_sums_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_V,
    ST_DIV_I,
    ST_DIV_P,
    ST_SQRT_V,
    ST_SQRT_I,
    ST_DONE
  } back_state_t;

endpackage

// ===== sv/rmspm_front.sv =====
// Front end: window length register, sample accept, squaring and accumulation.
// Pushes finished window sums into rmspm_fifo. Depends on rmspm_pkg.
module rmspm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rmspm_pkg::WLEN_BITS-1:0]  cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [2*rmspm_pkg::SAMPLE_BITS-1:0] s_tdata,
  input  logic [rmspm_pkg::QCNT_BITS-1:0]  q_count,
  output logic                             push,
  output rmspm_pkg::win_sums_t             push_data
);
  import rmspm_pkg::*;

  logic [WLEN_BITS-1:0]     win_len;
  logic [WLEN_BITS-1:0]     n_eff;
  logic [WLEN_BITS-1:0]     count;
  logic                     is_last;
  logic                     enter;
  logic [QCNT_BITS:0]       reserved;
  logic signed [SAMPLE_BITS-1:0] v_in;
  logic signed [SAMPLE_BITS-1:0] i_in;
  logic signed [SQ_BITS-1:0]     vv_full;
  logic signed [SQ_BITS-1:0]     ii_full;
  logic signed [SQ_BITS-1:0]     vi_full;

  // product stage
  logic                     s1_valid;
  logic                     s1_last;
  logic [SQ_BITS-1:0]       s1_vv;
  logic [SQ_BITS-1:0]       s1_ii;
  logic [SQ_BITS-1:0]       s1_vi;

  // accumulators
  logic [SQ_SUM_BITS-1:0]   vsq;
  logic [SQ_SUM_BITS-1:0]   isq;
  logic [PROD_SUM_BITS-1:0] psum;
  logic [SQ_SUM_BITS-1:0]   vsq_next;
  logic [SQ_SUM_BITS-1:0]   isq_next;
  logic [PROD_SUM_BITS-1:0] psum_next;

  // effective window and end-of-window detect
  always_comb begin
    if (win_len > WLEN_BITS'(MAX_WINDOW)) begin
      n_eff = WLEN_BITS'(MAX_WINDOW);
    end else begin
      n_eff = win_len;
    end
    is_last  = (WLEN_BITS'(count + 1'b1) == n_eff);
    reserved = {1'b0, q_count} + {{QCNT_BITS{1'b0}}, s1_valid & s1_last};
  end

  // a closing word needs a free queue slot; other words always go in
  assign s_tready = (n_eff == '0) || !is_last || (reserved < (QCNT_BITS+1)'(QUEUE_DEPTH));
  assign enter    = s_tvalid && s_tready && (n_eff != '0);

  assign v_in    = s_tdata[SAMPLE_BITS-1:0];
  assign i_in    = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign vv_full = v_in * v_in;
  assign ii_full = i_in * i_in;
  assign vi_full = v_in * i_in;

  // config register and sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len  <= WLEN_BITS'(WLEN_RESET);
      count    <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= enter;
      if (cfg_we) begin
        win_len <= cfg_wdata;
        count   <= '0;
      end else if (enter) begin
        count <= is_last ? '0 : WLEN_BITS'(count + 1'b1);
      end
    end
  end

  // product registers
  always_ff @(posedge clk) begin
    if (enter) begin
      s1_last <= is_last;
      s1_vv   <= vv_full;
      s1_ii   <= ii_full;
      s1_vi   <= vi_full;
    end
  end

  // accumulate
  always_comb begin
    vsq_next  = vsq + {{(SQ_SUM_BITS-SQ_BITS){1'b0}}, s1_vv};
    isq_next  = isq + {{(SQ_SUM_BITS-SQ_BITS){1'b0}}, s1_ii};
    psum_next = psum + {{(PROD_SUM_BITS-SQ_BITS){s1_vi[SQ_BITS-1]}}, s1_vi};
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      vsq  <= '0;
      isq  <= '0;
      psum <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        vsq  <= '0;
        isq  <= '0;
        psum <= '0;
      end else begin
        vsq  <= vsq_next;
        isq  <= isq_next;
        psum <= psum_next;
      end
    end
  end

  assign push           = s1_valid && s1_last;
  assign push_data.vsq  = vsq_next;
  assign push_data.isq  = isq_next;
  assign push_data.psum = psum_next;
  assign push_data.wlen = n_eff;

endmodule

// ===== sv/rmspm_fifo.sv =====
// Short queue of finished window sums between front and back end.
// Depends on rmspm_pkg.
module rmspm_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  rmspm_pkg::win_sums_t            push_data,
  input  logic                            pop,
  output rmspm_pkg::win_sums_t            head,
  output logic [rmspm_pkg::QCNT_BITS-1:0] count
);
  import rmspm_pkg::*;

  win_sums_t            mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head = mem[rd_ptr];

endmodule

// ===== sv/rmspm_back.sv =====
// Back end: shared restoring divider and shared bit-pair square root unit,
// sequenced per window, with an output register. Depends on rmspm_pkg.
module rmspm_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rmspm_pkg::QCNT_BITS-1:0]  q_count,
  input  rmspm_pkg::win_sums_t             head,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rmspm_pkg::RMS_BITS-1:0]   voltage_rms,
  output logic [rmspm_pkg::RMS_BITS-1:0]   current_rms,
  output logic [rmspm_pkg::POWER_BITS-1:0] real_power
);
  import rmspm_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [STEP_BITS-1:0]     step;
  logic                     div_last;
  logic                     sqrt_last;
  logic                     out_free;

  // held window
  logic [WLEN_BITS-1:0]     n;
  logic [SQ_SUM_BITS-1:0]   isq_hold;
  logic [PROD_SUM_BITS-1:0] pmag;
  logic                     pneg;
  logic [PROD_SUM_BITS-1:0] head_mag;

  // divider
  logic [DIV_BITS-1:0]      dq;
  logic [REM_BITS-1:0]      rem;
  logic [REM_BITS:0]        rem_sh;
  logic                     div_ge;
  logic [REM_BITS:0]        rem_sub;
  logic [REM_BITS-1:0]      rem_step;
  logic [DIV_BITS-1:0]      dq_step;

  // square root
  logic [SQRT_IN_BITS-1:0]  sx;
  logic [SREM_BITS-1:0]     srem;
  logic [RMS_BITS-1:0]      root;
  logic [SREM_BITS-1:0]     srem_sh;
  logic [SREM_BITS-1:0]     trial;
  logic                     sq_ge;
  logic [SREM_BITS-1:0]     srem_step;
  logic [RMS_BITS-1:0]      root_step;

  // results
  logic [SQRT_IN_BITS-1:0]  qv;
  logic [SQRT_IN_BITS-1:0]  qi;
  logic [RMS_BITS-1:0]      vrms;
  logic [RMS_BITS-1:0]      irms;
  logic [POWER_BITS-1:0]    power;

  // one divider step: shift in a dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem, dq[DIV_BITS-1]};
    div_ge   = (rem_sh >= {1'b0, n});
    rem_sub  = rem_sh - {1'b0, n};
    rem_step = div_ge ? rem_sub[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
    dq_step  = {dq[DIV_BITS-2:0], div_ge};
  end

  // one square root step: two radicand bits per step
  always_comb begin
    srem_sh   = {srem[SREM_BITS-3:0], sx[SQRT_IN_BITS-1 -: 2]};
    trial     = {2'b00, root, 2'b01};
    sq_ge     = (srem_sh >= trial);
    srem_step = sq_ge ? (srem_sh - trial) : srem_sh;
    root_step = {root[RMS_BITS-2:0], sq_ge};
  end

  assign head_mag  = head.psum[PROD_SUM_BITS-1] ? (~head.psum + 1'b1) : head.psum;
  assign div_last  = (step == STEP_BITS'(DIV_BITS - 1));
  assign sqrt_last = (step == STEP_BITS'(SQRT_ITERS - 1));
  assign out_free  = !m_tvalid || m_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_count != '0) begin
          pop        = 1'b1;
          state_next = ST_DIV_V;
        end
      end
      ST_DIV_V:  if (div_last) state_next = ST_DIV_I;
      ST_DIV_I:  if (div_last) state_next = ST_DIV_P;
      ST_DIV_P:  if (div_last) state_next = ST_SQRT_V;
      ST_SQRT_V: if (sqrt_last) state_next = ST_SQRT_I;
      ST_SQRT_I: if (sqrt_last) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if ((state == ST_IDLE) || (div_last && (state == ST_DIV_V || state == ST_DIV_I ||
               state == ST_DIV_P)) || (sqrt_last && (state == ST_SQRT_V ||
               state == ST_SQRT_I))) begin
      step <= '0;
    end else begin
      step <= step + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop) begin
          n        <= head.wlen;
          isq_hold <= head.isq;
          pmag     <= head_mag;
          pneg     <= head.psum[PROD_SUM_BITS-1];
          dq       <= {1'b0, head.vsq};
          rem      <= '0;
        end
      end
      ST_DIV_V: begin
        dq  <= dq_step;
        rem <= rem_step;
        if (div_last) begin
          qv  <= dq_step[SQRT_IN_BITS-1:0];
          dq  <= {1'b0, isq_hold};
          rem <= '0;
        end
      end
      ST_DIV_I: begin
        dq  <= dq_step;
        rem <= rem_step;
        if (div_last) begin
          qi  <= dq_step[SQRT_IN_BITS-1:0];
          dq  <= pmag;
          rem <= '0;
        end
      end
      ST_DIV_P: begin
        dq  <= dq_step;
        rem <= rem_step;
        if (div_last) begin
          power <= pneg ? (~dq_step[POWER_BITS-1:0] + 1'b1) : dq_step[POWER_BITS-1:0];
          sx    <= qv;
          srem  <= '0;
          root  <= '0;
        end
      end
      ST_SQRT_V: begin
        sx   <= {sx[SQRT_IN_BITS-3:0], 2'b00};
        srem <= srem_step;
        root <= root_step;
        if (sqrt_last) begin
          vrms <= root_step;
          sx   <= qi;
          srem <= '0;
          root <= '0;
        end
      end
      ST_SQRT_I: begin
        sx   <= {sx[SQRT_IN_BITS-3:0], 2'b00};
        srem <= srem_step;
        root <= root_step;
        if (sqrt_last) begin
          irms <= root_step;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      voltage_rms <= vrms;
      current_rms <= irms;
      real_power  <= power;
    end
  end

endmodule

// ===== sv/rms_and_power_window_meter.sv =====
// Top level of the RMS and real power window meter.
// Instantiates rmspm_front, rmspm_fifo and rmspm_back; depends on rmspm_pkg.
//
//  channel  dir  handshake          word
//  s_*      in   s_tvalid/s_tready  voltage_sample, current_sample
//  m_*      out  m_tvalid/m_tready  voltage_rms, current_rms, real_power
//  cfg_*    in   cfg_we             window_length
//
// Samples are taken one per cycle; the closing sample of a window waits only
// when both queue slots hold unfinished windows.
// Each window then passes through the back end in turn: the shared one-bit-per-cycle divider
// forms the three means, then the two-bit-per-cycle root unit takes the two roots.
// A finished result sits in the output register while the next window runs.
// rst (synchronous) sets window_length to 64 and clears sums, queue and output.
module rms_and_power_window_meter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,   // window_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // [15:0] voltage_sample, [31:16] current_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata      // [15:0] voltage_rms, [31:16] current_rms,
                                   // [63:32] real_power
);
  import rmspm_pkg::*;

  logic                  push;
  logic                  pop;
  win_sums_t             push_data;
  win_sums_t             head;
  logic [QCNT_BITS-1:0]  q_count;
  logic [RMS_BITS-1:0]   voltage_rms;
  logic [RMS_BITS-1:0]   current_rms;
  logic [POWER_BITS-1:0] real_power;

  rmspm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  rmspm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  rmspm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_count     (q_count),
    .head        (head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .voltage_rms (voltage_rms),
    .current_rms (current_rms),
    .real_power  (real_power)
  );

  assign m_tdata = {real_power, current_rms, voltage_rms};

`ifndef NO_ASSERTIONS
  // a closing window never finds the queue full
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count < QCNT_BITS'(QUEUE_DEPTH)))
    else $error("window pushed into full queue");

  // back end only takes a window that is there
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_count != '0))
    else $error("window popped from empty queue");

  // a pop always frees a slot in the next cycle unless a push refills it
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (q_count == $past(q_count) - 1'b1))
    else $error("queue count did not drop after pop");
`endif

endmodule

// ===== tb/sv/tb_rms_and_power_window_meter.sv =====
// Self-checking testbench for rms_and_power_window_meter: a directed table, then random
// windows of sample pairs, each reading checked against an in-bench window predictor.
// Depends on rmspm_pkg and the RTL of the meter; needs nothing else.
module tb_rms_and_power_window_meter;

  localparam int WATCHDOG_LIMIT    = 10000;
  localparam int DRAIN_CYCLES      = 200;
  localparam int HOLD_CYCLES       = 1500;
  localparam int ITEM_TARGET       = 1100;
  localparam int RESULT_TARGET     = 48;

  typedef logic signed [rmspm_pkg::SAMPLE_BITS-1:0] sample_t;

  // Same layout as m_tdata, lowest field last
  typedef struct packed {
    logic signed [rmspm_pkg::POWER_BITS-1:0] real_power;
    logic [rmspm_pkg::RMS_BITS-1:0]          current_rms;
    logic [rmspm_pkg::RMS_BITS-1:0]          voltage_rms;
  } meter_reading_t;

  typedef enum logic {ROW_WINDOW, ROW_PAIR} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [rmspm_pkg::WLEN_BITS-1:0] window;
    sample_t                        v;
    sample_t                        i;
    bit                             typed;
    meter_reading_t                 reading;
  } plan_row_t;

  // DUT ports; every input known from time zero
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;    // [15:0] voltage_sample, [31:16] current_sample
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;           // [15:0] voltage_rms, [31:16] current_rms, [63:32] real_power

  // Window predictor state
  logic [rmspm_pkg::WLEN_BITS-1:0]     win_len = 11'(rmspm_pkg::WLEN_RESET);
  logic [rmspm_pkg::SQ_SUM_BITS-1:0]   win_vsq = '0;
  logic [rmspm_pkg::SQ_SUM_BITS-1:0]   win_isq = '0;
  logic [rmspm_pkg::PROD_SUM_BITS-1:0] win_psum = '0;
  logic [rmspm_pkg::WLEN_BITS-1:0]     win_count = '0;

  meter_reading_t readings_due[$];
  plan_row_t      plan[$];
  int unsigned    results_seen   = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    burst_left     = 0;
  int unsigned    quiet_cycles   = 0;
  int unsigned    items_sent     = 0;

  // Receiver pattern and long hold-off handshake
  logic        hold_req  = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rcv_tick  = 0;
  int unsigned rcv_mode  = 0;

  always #5 clk = ~clk;

  rms_and_power_window_meter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Floor square root, one result bit per pass from the top
  function automatic logic [rmspm_pkg::RMS_BITS-1:0] floor_root(input longint unsigned x);
    logic [20:0]       root;
    longint unsigned   t;
    root = '0;
    for (int b = 20; b >= 0; b--) begin
      t = root | (21'd1 << b);
      if (t * t <= x) root = t[20:0];
    end
    return root[rmspm_pkg::RMS_BITS-1:0];
  endfunction

  function automatic void meter_clear();
    win_vsq   = '0;
    win_isq   = '0;
    win_psum  = '0;
    win_count = '0;
  endfunction

  // Expected readings, oldest first
  function automatic void due_append(input meter_reading_t r);
    readings_due.insert(readings_due.size(), r);
  endfunction

  function automatic meter_reading_t due_take();
    meter_reading_t r;
    r = readings_due[0];
    readings_due.delete(0);
    return r;
  endfunction

  function automatic void plan_add(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // Adds one pair to the window; returns 1 with the reading when the window closes
  function automatic bit meter_take_pair(input sample_t v, input sample_t i,
                                         output meter_reading_t r);
    longint n;
    longint sv;
    longint si;
    longint p;
    n = (win_len > rmspm_pkg::MAX_WINDOW) ? rmspm_pkg::MAX_WINDOW : win_len;
    r = '0;
    if (n == 0) return 1'b0;   // window disabled: pair ignored
    sv = v;
    si = i;
    win_vsq   = win_vsq + 41'(sv * sv);
    win_isq   = win_isq + 41'(si * si);
    win_psum  = win_psum + 42'(sv * si);
    win_count = win_count + 1'b1;
    if (win_count < n) return 1'b0;
    r.voltage_rms = floor_root(longint'(win_vsq) / n);
    r.current_rms = floor_root(longint'(win_isq) / n);
    p = $signed(win_psum);
    r.real_power = 32'(p / n);   // integer divide truncates toward zero
    meter_clear();
    return 1'b1;
  endfunction

  function automatic sample_t draw_sample(input int unsigned style);
    case (style)
      0: return sample_t'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0:       return sample_t'(-32768);
          1:       return sample_t'(32767);
          2:       return sample_t'(-1);
          3:       return sample_t'(0);
          4:       return sample_t'(1);
          default: return sample_t'($urandom);
        endcase
      end
      2: return sample_t'($urandom_range(0, 32) - 16);
      // near-full-scale: pushes the sums toward their limits
      default: return ($urandom_range(0, 7) == 0) ? sample_t'(32767) : sample_t'(-32768);
    endcase
  endfunction

  function automatic plan_row_t window_row(input int unsigned w);
    plan_row_t r;
    r = '{kind: ROW_WINDOW, window: 11'(w), v: '0, i: '0, typed: 1'b0, reading: '0};
    return r;
  endfunction

  function automatic plan_row_t pair_row(input int v, input int i);
    plan_row_t r;
    r = '{kind: ROW_PAIR, window: '0, v: sample_t'(v), i: sample_t'(i), typed: 1'b0,
          reading: '0};
    return r;
  endfunction

  function automatic plan_row_t checked_row(input int v, input int i,
                                            input logic [15:0] vr, input logic [15:0] ir,
                                            input logic signed [31:0] pw);
    plan_row_t r;
    r = pair_row(v, i);
    r.typed = 1'b1;
    r.reading.voltage_rms = vr;
    r.reading.current_rms = ir;
    r.reading.real_power  = pw;
    return r;
  endfunction

  // Drop valid, wait for every reading due, then let the back end go quiet
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input int unsigned w);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= 11'(w);
    @(posedge clk);
    cfg_we  <= 1'b0;
    win_len = 11'(w);
    meter_clear();
  endtask

  // Offer one sample word in bursts with random gaps; predict once accepted
  task automatic send_pair(input sample_t v, input sample_t i, input bit typed,
                           input meter_reading_t typed_reading);
    meter_reading_t predicted;
    int unsigned    gap;
    bit             due;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {i, v};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    due = meter_take_pair(v, i, predicted);
    if (typed) due_append(typed_reading);
    else if (due) due_append(predicted);
  endtask

  // Receiver: one of three ready patterns, long hold-off on request
  always @(posedge clk) begin
    rcv_tick <= rcv_tick + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (rcv_tick % 256 == 0) rcv_mode <= $urandom_range(0, 2);
      case (rcv_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= (rcv_tick % 7) >= 3;
      endcase
    end
  end

  // Compare each accepted reading with the oldest one due
  always @(posedge clk) begin : check_readings
    meter_reading_t got;
    meter_reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      if (readings_due.size() == 0) begin
        mismatch_count++;
        $error("unexpected reading: voltage_rms %0d current_rms %0d real_power %0d",
               got.voltage_rms, got.current_rms, got.real_power);
      end else begin
        want = due_take();
        if (got.voltage_rms !== want.voltage_rms) begin
          mismatch_count++;
          $error("voltage_rms: expected %0d, got %0d", want.voltage_rms, got.voltage_rms);
        end
        if (got.current_rms !== want.current_rms) begin
          mismatch_count++;
          $error("current_rms: expected %0d, got %0d", want.current_rms, got.current_rms);
        end
        if (got.real_power !== want.real_power) begin
          mismatch_count++;
          $error("real_power: expected %0d, got %0d", want.real_power, got.real_power);
        end
      end
    end
  end

  // Watchdog: cycles with no word moved and no register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned w;
    int unsigned eff;
    int unsigned count;
    int unsigned style;
    int unsigned phase;
    phase = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Partial window at the reset length, then disabled: pairs ignored
    plan_add(pair_row(32767, -32768));
    plan_add(pair_row(-32768, 32767));
    plan_add(pair_row(0, 0));
    plan_add(window_row(0));
    plan_add(pair_row(-32768, -32768));
    plan_add(pair_row(12345, -2));
    // One-sample windows: full scale root is exactly 32768
    plan_add(window_row(1));
    plan_add(checked_row(-32768, -32768, 16'd32768, 16'd32768, 1073741824));
    plan_add(checked_row(32767, -32768, 16'd32767, 16'd32768, -1073709056));
    plan_add(checked_row(0, 0, 16'd0, 16'd0, 0));
    plan_add(checked_row(-1, 1, 16'd1, 16'd1, -1));
    // Means truncate; negative power truncates toward zero
    plan_add(window_row(2));
    plan_add(pair_row(3, -5));
    plan_add(checked_row(-3, 4, 16'd3, 16'd4, -13));
    plan_add(pair_row(1, -1));
    plan_add(checked_row(0, 0, 16'd0, 16'd0, 0));
    plan_add(window_row(3));
    plan_add(pair_row(2, 2));
    plan_add(pair_row(2, 2));
    plan_add(checked_row(3, 3, 16'd2, 16'd2, 5));
    // Oversized length, then a write that must drop the partial sums
    plan_add(window_row(2047));
    plan_add(pair_row(100, 100));
    plan_add(pair_row(200, -7));
    plan_add(window_row(1024));
    plan_add(pair_row(5, 5));
    plan_add(window_row(1));
    plan_add(checked_row(7, -9, 16'd7, 16'd9, -63));

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WINDOW) write_window(plan[k].window);
      else send_pair(plan[k].v, plan[k].i, plan[k].typed, plan[k].reading);
    end

    // Random windows: extremes first, then mostly short windows
    while (items_sent < ITEM_TARGET ||
           results_seen + readings_due.size() < RESULT_TARGET) begin
      style = $urandom_range(0, 3);
      case (phase)
        0:       w = rmspm_pkg::WLEN_RESET;
        1:       w = 1;
        2:       w = 2047;
        3:       w = rmspm_pkg::MAX_WINDOW;
        4:       w = 0;
        5:       w = $urandom_range(rmspm_pkg::MAX_WINDOW + 1, 2046);
        default: w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 64);
      endcase
      write_window(w);
      eff = (w > rmspm_pkg::MAX_WINDOW) ? rmspm_pkg::MAX_WINDOW : w;
      // oversized length acts as the longest window; near full scale
      if (phase == 2) style = 3;
      if (eff == 0 || eff > 64) begin
        count = $urandom_range(8, 60);
      end else begin
        count = eff * $urandom_range(1, 6) + $urandom_range(0, eff - 1);
      end
      if (phase == 1) begin
        // receiver holds off while one-sample windows pile up
        count = 40;
        hold_req <= ~hold_req;
      end
      repeat (count) send_pair(draw_sample(style), draw_sample(style), 1'b0, '0);
      phase++;
    end

    settle_idle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
